// ===== rtl/core/dtfb_pkg.sv =====
// Shared constants, types and divider step functions for depth_to_focus_byte.
package dtfb_pkg;

   localparam int DEPTH_BITS    = 24;
   localparam int DISTANCE_BITS = 24;
   localparam int RANGE_BITS    = DISTANCE_BITS - 1;
   localparam int BYTE_BITS     = 8;
   localparam int CSR_W         = DISTANCE_BITS;
   localparam int PROD_W        = DEPTH_BITS + DISTANCE_BITS;
   localparam int FN_W          = 2 * DISTANCE_BITS;
   localparam int NUM_W         = FN_W + DEPTH_BITS;
   localparam int DEN_W         = PROD_W + 1;
   localparam int BAND_W        = DISTANCE_BITS + 2;
   localparam int SCALED_W      = DISTANCE_BITS + BYTE_BITS;

   localparam logic [DISTANCE_BITS-1:0] NEAR_RESET  = DISTANCE_BITS'(64);
   localparam logic [DISTANCE_BITS-1:0] FAR_RESET   = DISTANCE_BITS'(1048576);
   localparam logic [DISTANCE_BITS-1:0] FOCUS_RESET = DISTANCE_BITS'(16384);
   localparam logic [RANGE_BITS-1:0]    RANGE_RESET = '0;
   localparam logic [BYTE_BITS-1:0]     BYTE_MAX    = '1;

   typedef enum logic [1:0] {
      CSR_NEAR  = 2'd0,
      CSR_FAR   = 2'd1,
      CSR_FOCUS = 2'd2,
      CSR_RANGE = 2'd3
   } csr_index_type;

   // one bit of the distance divide per stage
   typedef struct packed {
      logic                     valid;
      logic                     eof;
      logic                     sat;
      logic [DEN_W-1:0]         den;
      logic [DEN_W-1:0]         rem;
      logic [DISTANCE_BITS-1:0] quo;
   } lin_stage_type;

   // one bit of the band divide per stage
   typedef struct packed {
      logic                     valid;
      logic                     eof;
      logic                     below;
      logic                     above;
      logic [DISTANCE_BITS-1:0] width;
      logic [DISTANCE_BITS-1:0] rem;
      logic [BYTE_BITS-1:0]     low_bits;
      logic [BYTE_BITS-1:0]     quo;
   } band_stage_type;

   // restoring step: {quotient bit, new remainder}
   function automatic logic [DEN_W:0] lin_div_step(input logic [DEN_W-1:0] rem,
                                                   input logic [DEN_W-1:0] den,
                                                   input logic             bit_in);
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      logic [DEN_W:0] diff;
      t    = {rem, bit_in};
      d    = {1'b0, den};
      diff = t - d;
      if (t >= d) begin
         lin_div_step = {1'b1, diff[DEN_W-1:0]};
      end else begin
         lin_div_step = {1'b0, t[DEN_W-1:0]};
      end
   endfunction

   function automatic logic [DISTANCE_BITS:0] band_div_step(
      input logic [DISTANCE_BITS-1:0] rem,
      input logic [DISTANCE_BITS-1:0] den,
      input logic                     bit_in);
      logic [DISTANCE_BITS:0] t;
      logic [DISTANCE_BITS:0] d;
      logic [DISTANCE_BITS:0] diff;
      t    = {rem, bit_in};
      d    = {1'b0, den};
      diff = t - d;
      if (t >= d) begin
         band_div_step = {1'b1, diff[DISTANCE_BITS-1:0]};
      end else begin
         band_div_step = {1'b0, t[DISTANCE_BITS-1:0]};
      end
   endfunction

endpackage

// ===== rtl/core/depth_to_focus_byte.sv =====
// Depth-buffer linearization into an 8-bit focus-band position, deep pipeline.
// Pipeline stages: 1 input, 2 multiply/add, 1 compare, 24 distance-divide steps,
// 1 band compare, 1 scale, 8 band-divide steps.
// Throughput: one request per cycle; a two-entry output buffer absorbs a stalled result,
// and the pipeline freezes only while both entries are occupied.
// Reset: synchronous, clears all valid bits and loads the register reset values.
module depth_to_focus_byte (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [dtfb_pkg::DEPTH_BITS-1:0]      req_depth_sample,
   input  logic                                 req_end_of_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dtfb_pkg::BYTE_BITS-1:0]       rsp_focus_byte,
   output logic                                 rsp_frame_done,
   input  logic                                 csr_write_en,
   input  dtfb_pkg::csr_index_type              csr_index,
   input  logic [dtfb_pkg::CSR_W-1:0]           csr_write_data
);
   import dtfb_pkg::*;

   // configuration
   logic [DISTANCE_BITS-1:0] csr_near_ff;
   logic [DISTANCE_BITS-1:0] csr_far_ff;
   logic [DISTANCE_BITS-1:0] csr_focus_ff;
   logic [RANGE_BITS-1:0]    csr_range_ff;

   logic [FN_W-1:0]          cfg_fn_ff;
   logic [DISTANCE_BITS-1:0] cfg_diff_ff;
   logic                     cfg_far_ge_ff;
   logic [BAND_W-1:0]        cfg_start_ff;
   logic [DISTANCE_BITS:0]   cfg_end_ff;
   logic [DISTANCE_BITS-1:0] cfg_width_ff;
   logic [NUM_W-1:0]         cfg_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_near_ff  <= NEAR_RESET;
         csr_far_ff   <= FAR_RESET;
         csr_focus_ff <= FOCUS_RESET;
         csr_range_ff <= RANGE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_NEAR:  csr_near_ff  <= csr_write_data[DISTANCE_BITS-1:0];
            CSR_FAR:   csr_far_ff   <= csr_write_data[DISTANCE_BITS-1:0];
            CSR_FOCUS: csr_focus_ff <= csr_write_data[DISTANCE_BITS-1:0];
            CSR_RANGE: csr_range_ff <= csr_write_data[RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cfg_fn_ff     <= FN_W'(csr_far_ff) * FN_W'(csr_near_ff);
      cfg_far_ge_ff <= csr_far_ff >= csr_near_ff;
      cfg_diff_ff   <= (csr_far_ff >= csr_near_ff) ? csr_far_ff - csr_near_ff
                                                  : csr_near_ff - csr_far_ff;
      cfg_start_ff  <= BAND_W'(csr_focus_ff) - BAND_W'(csr_range_ff);
      cfg_end_ff    <= (DISTANCE_BITS+1)'(csr_focus_ff) + (DISTANCE_BITS+1)'(csr_range_ff);
      cfg_width_ff  <= {csr_range_ff, 1'b0};
   end

   assign cfg_num = {cfg_fn_ff, {DEPTH_BITS{1'b0}}};

   // flow control
   logic adv;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic [BYTE_BITS-1:0] out_byte_ff, out_byte_in, skid_byte_ff, skid_byte_in;
   logic out_eof_ff, out_eof_in, skid_eof_ff, skid_eof_in;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage A: input
   logic                  a_valid_ff, a_eof_ff;
   logic [DEPTH_BITS-1:0] a_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid && (csr_range_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_eof_ff   <= req_end_of_frame;
         a_depth_ff <= req_depth_sample;
      end
   end

   // stage B: depth * |far - near|
   logic              b_valid_ff, b_eof_ff;
   logic [PROD_W-1:0] b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_eof_ff  <= a_eof_ff;
         b_prod_ff <= PROD_W'(a_depth_ff) * PROD_W'(cfg_diff_ff);
      end
   end

   // stage C: denominator
   logic              c_valid_ff, c_eof_ff;
   logic [DEN_W-1:0]  c_den_ff;
   logic [PROD_W-1:0] far_scaled;

   assign far_scaled = {csr_far_ff, {DEPTH_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_eof_ff <= b_eof_ff;
         c_den_ff <= cfg_far_ge_ff ? DEN_W'(far_scaled) - DEN_W'(b_prod_ff)
                                   : DEN_W'(far_scaled) + DEN_W'(b_prod_ff);
      end
   end

   // distance divider: saturation check, then one quotient bit per stage
   lin_stage_type lin_ff [0:DISTANCE_BITS];
   lin_stage_type lin0_in;

   always_comb begin
      lin0_in.valid = c_valid_ff;
      lin0_in.eof   = c_eof_ff;
      lin0_in.den   = c_den_ff;
      lin0_in.sat   = DEN_W'(cfg_num[NUM_W-1:DISTANCE_BITS]) >= c_den_ff;
      lin0_in.rem   = DEN_W'(cfg_num[NUM_W-1:DISTANCE_BITS]);
      lin0_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff[0].valid <= 1'b0;
      end else if (adv) begin
         lin_ff[0] <= lin0_in;
      end
   end

   for (genvar k = 1; k <= DISTANCE_BITS; k++) begin : g_lin
      logic [DEN_W:0] step_res;
      lin_stage_type  lin_in;

      assign step_res = lin_div_step(lin_ff[k-1].rem, lin_ff[k-1].den,
                                     cfg_num[DISTANCE_BITS-k]);

      always_comb begin
         lin_in     = lin_ff[k-1];
         lin_in.rem = step_res[DEN_W-1:0];
         lin_in.quo = {lin_ff[k-1].quo[DISTANCE_BITS-2:0], step_res[DEN_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            lin_ff[k].valid <= 1'b0;
         end else if (adv) begin
            lin_ff[k] <= lin_in;
         end
      end
   end

   // stage E: position against the band
   logic                     e_valid_ff, e_eof_ff, e_below_ff, e_above_ff;
   logic [DISTANCE_BITS-1:0] e_x_ff;
   logic [DISTANCE_BITS-1:0] z_dist;
   logic [BAND_W-1:0]        dz;

   assign z_dist = lin_ff[DISTANCE_BITS].sat ? '1 : lin_ff[DISTANCE_BITS].quo;
   assign dz     = BAND_W'(z_dist) - cfg_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= lin_ff[DISTANCE_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_eof_ff   <= lin_ff[DISTANCE_BITS].eof;
         e_below_ff <= dz[BAND_W-1] || (dz == '0);
         e_above_ff <= (DISTANCE_BITS+1)'(z_dist) >= cfg_end_ff;
         e_x_ff     <= dz[DISTANCE_BITS-1:0];
      end
   end

   // band divider: (x * 255) / (2 * range)
   band_stage_type            band_ff [0:BYTE_BITS];
   band_stage_type            band0_in;
   logic [SCALED_W-1:0]       scaled;

   assign scaled = {e_x_ff, {BYTE_BITS{1'b0}}} - SCALED_W'(e_x_ff);

   always_comb begin
      band0_in.valid    = e_valid_ff;
      band0_in.eof      = e_eof_ff;
      band0_in.below    = e_below_ff;
      band0_in.above    = e_above_ff;
      band0_in.width    = cfg_width_ff;
      band0_in.rem      = scaled[SCALED_W-1:BYTE_BITS];
      band0_in.low_bits = scaled[BYTE_BITS-1:0];
      band0_in.quo      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff[0].valid <= 1'b0;
      end else if (adv) begin
         band_ff[0] <= band0_in;
      end
   end

   for (genvar j = 1; j <= BYTE_BITS; j++) begin : g_band
      logic [DISTANCE_BITS:0] step_res;
      band_stage_type         band_in;

      assign step_res = band_div_step(band_ff[j-1].rem, band_ff[j-1].width,
                                      band_ff[j-1].low_bits[BYTE_BITS-1]);

      always_comb begin
         band_in          = band_ff[j-1];
         band_in.rem      = step_res[DISTANCE_BITS-1:0];
         band_in.low_bits = {band_ff[j-1].low_bits[BYTE_BITS-2:0], 1'b0};
         band_in.quo      = {band_ff[j-1].quo[BYTE_BITS-2:0], step_res[DISTANCE_BITS]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            band_ff[j].valid <= 1'b0;
         end else if (adv) begin
            band_ff[j] <= band_in;
         end
      end
   end

   // output buffer: result register plus skid entry
   logic                 push, pop;
   logic [BYTE_BITS-1:0] new_byte;

   assign push     = adv && band_ff[BYTE_BITS].valid;
   assign pop      = out_valid_ff && !rsp_stall;
   assign new_byte = band_ff[BYTE_BITS].below ? '0 :
                     band_ff[BYTE_BITS].above ? BYTE_MAX : band_ff[BYTE_BITS].quo;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_eof_in    = out_eof_ff;
      skid_valid_in = skid_valid_ff;
      skid_byte_in  = skid_byte_ff;
      skid_eof_in   = skid_eof_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_byte_in   = skid_byte_ff;
            out_eof_in    = skid_eof_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in = push;
         out_byte_in  = new_byte;
         out_eof_in   = band_ff[BYTE_BITS].eof;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_byte_in  = new_byte;
         skid_eof_in   = band_ff[BYTE_BITS].eof;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_eof_ff   <= out_eof_in;
      skid_byte_ff <= skid_byte_in;
      skid_eof_ff  <= skid_eof_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_focus_byte = out_byte_ff;
   assign rsp_frame_done = out_eof_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without result register");

   a_zero_range_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && csr_range_ff == '0) |=> !a_valid_ff)
      else $error("request entered pipeline with zero focus range");

   a_lin_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (lin_ff[DISTANCE_BITS].valid && !lin_ff[DISTANCE_BITS].sat) |->
         (lin_ff[DISTANCE_BITS].rem < lin_ff[DISTANCE_BITS].den))
      else $error("distance divider remainder out of bound");

   a_band_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (band_ff[BYTE_BITS].valid && !band_ff[BYTE_BITS].below &&
       !band_ff[BYTE_BITS].above) |-> (band_ff[BYTE_BITS].quo != BYTE_MAX))
      else $error("in-band quotient reached full scale");
`endif

endmodule
